### hw/rtl/psru_pkg.sv
package psru_pkg;

	localparam int NumSegments = 16;
	localparam int SegIdxW     = $clog2(NumSegments);

	localparam int InDataW  = 216;
	localparam int InPadW   = 224;
	localparam int OutDataW = 67;
	localparam int OutPadW  = 72;

	localparam logic [31:0] MsrPrBit      = 32'h0000_4000;
	localparam logic [31:0] MsrIrBit      = 32'h0000_0020;
	localparam logic [31:0] MsrDrBit      = 32'h0000_0010;
	localparam logic [31:0] RfiKeepMask   = 32'h87C0_FF73;
	localparam logic [31:0] RfiClearExtra = 32'h0004_0000;

	// TO mask bits of tw / twi
	localparam logic [4:0] ToLt  = 5'h10;
	localparam logic [4:0] ToGt  = 5'h08;
	localparam logic [4:0] ToEq  = 5'h04;
	localparam logic [4:0] ToLtu = 5'h02;
	localparam logic [4:0] ToGtu = 5'h01;

	typedef enum logic [3:0] {
		REQ_TW     = 4'd0,
		REQ_TWI    = 4'd1,
		REQ_MTCRF  = 4'd2,
		REQ_MCRXR  = 4'd3,
		REQ_MFCR   = 4'd4,
		REQ_MFMSR  = 4'd5,
		REQ_MTMSR  = 4'd6,
		REQ_MFSR   = 4'd7,
		REQ_MFSRIN = 4'd8,
		REQ_MTSR   = 4'd9,
		REQ_MTSRIN = 4'd10,
		REQ_RFI    = 4'd11,
		REQ_SC     = 4'd12,
		REQ_XERW   = 4'd13
	} req_t;

	typedef enum logic [1:0] {
		EXC_NONE    = 2'd0,
		EXC_TRAP    = 2'd1,
		EXC_PRIV    = 2'd2,
		EXC_SYSCALL = 2'd3
	} exc_t;

	typedef struct packed {
		logic [31:0] srr1_value;
		logic [31:0] srr0_value;
		logic [7:0]  field_value;
		logic [15:0] imm_value;
		logic [31:0] rs_value;
		logic [31:0] rb_value;
		logic [31:0] ra_value;
		logic [31:0] cur_pc;
	} req_data_t;

endpackage

### hw/rtl/ppc_system_register_unit.sv
// PowerPC system register and trap unit.
//
// Input channel s_axis: one decoded system instruction per word; the
// operation code rides in s_axis_tuser, the operands in s_axis_tdata.
// Output channel m_axis: one result word per instruction, in order; the
// exception kind rides in m_axis_tuser.
// Throughput is one instruction per cycle while m_axis_tready stays high. The
// segment register read (a synchronous 16 x 32 memory) is taken at the
// accepting edge and registered with the instruction into the execute stage;
// execute then loads the output register that drives m_axis_tvalid.
// CR, MSR and the XER flags sit in flops and are updated as an instruction
// leaves the execute stage, so the next instruction sees them at once. A
// segment write that meets a read of the same entry is forwarded.
// Reset clears CR, MSR, XER flags and marks every segment register as zero
// through per-entry valid bits; no clearing pass is needed.
// When m_axis_tready is low the result holds in the output register, the
// execute stage holds one more instruction, and s_axis_tready drops only
// once both are full.
module ppc_system_register_unit
	import psru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// cur_pc, ra_value, rb_value, rs_value, imm_value, field_value,
	// srr0_value, srr1_value, zero pad
	input  logic [InPadW-1:0]   s_axis_tdata,
	// req_type
	input  logic [3:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// next_pc, rd_value, rd_write, itlb_flush, dtlb_flush, zero pad
	output logic [OutPadW-1:0]  m_axis_tdata,
	// exception_kind
	output logic [1:0]          m_axis_tuser
);

	req_data_t              in_d;
	req_t                   in_type;
	logic                   s_acc;
	logic [SegIdxW-1:0]     rd_idx;

	logic                   s1_vld_q;
	req_t                   type_s1;
	req_data_t              d_s1;
	logic                   s1_go;

	logic [31:0]            seg_mem [NumSegments];
	logic [NumSegments-1:0] seg_vld_q;
	logic [31:0]            seg_rd_s1;
	logic                   seg_rdv_s1;
	logic                   seg_hit_s1;
	logic [31:0]            seg_fwd_s1;
	logic [31:0]            seg_val;
	logic                   seg_wr;
	logic [SegIdxW-1:0]     wr_idx;

	logic [31:0]            cr_q, msr_q;
	logic [3:0]             xer_q;
	logic [31:0]            cr_nx, msr_nx;
	logic [3:0]             xer_nx;

	logic [31:0]            trap_b, crf_mask, cr_xer;
	logic                   trap_hit, fault;
	logic [4:0]             to_mask;

	logic [31:0]            npc_nx, rd_nx;
	logic                   rdw_nx, ifl_nx, dfl_nx;
	exc_t                   exc_nx;

	logic                   out_vld_q;
	logic [31:0]            npc_q, rd_q;
	logic                   rdw_q, ifl_q, dfl_q;
	exc_t                   exc_q;

	assign in_d    = s_axis_tdata[InDataW-1:0];
	assign in_type = req_t'(s_axis_tuser);
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign rd_idx  = (in_type == REQ_MFSRIN) ? in_d.rb_value[31:28]
	                                         : in_d.field_value[SegIdxW-1:0];

	assign s1_go         = s1_vld_q && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !s1_vld_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_go) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			type_s1    <= in_type;
			d_s1       <= in_d;
			seg_rd_s1  <= seg_mem[rd_idx];
			seg_rdv_s1 <= seg_vld_q[rd_idx];
			seg_hit_s1 <= seg_wr && (wr_idx == rd_idx);
			seg_fwd_s1 <= d_s1.rs_value;
		end
	end

	// segment memory: write from execute, entries never written read as zero
	assign wr_idx = (type_s1 == REQ_MTSRIN) ? d_s1.rb_value[31:28]
	                                        : d_s1.field_value[SegIdxW-1:0];
	assign seg_wr = s1_go && !fault
	                && ((type_s1 == REQ_MTSR) || (type_s1 == REQ_MTSRIN));

	always_ff @(posedge clk) begin
		if (seg_wr) begin
			seg_mem[wr_idx] <= d_s1.rs_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_vld_q <= '0;
		end else if (seg_wr) begin
			seg_vld_q[wr_idx] <= 1'b1;
		end
	end

	assign seg_val = seg_hit_s1 ? seg_fwd_s1 : (seg_rdv_s1 ? seg_rd_s1 : 32'h0);

	// trap compare
	assign trap_b  = (type_s1 == REQ_TWI) ? {{16{d_s1.imm_value[15]}}, d_s1.imm_value}
	                                      : d_s1.rb_value;
	assign to_mask = d_s1.field_value[4:0];
	assign trap_hit =
		((|(to_mask & ToLt))  && ($signed(d_s1.ra_value) <  $signed(trap_b))) ||
		((|(to_mask & ToGt))  && ($signed(d_s1.ra_value) >  $signed(trap_b))) ||
		((|(to_mask & ToEq))  && (d_s1.ra_value == trap_b)) ||
		((|(to_mask & ToLtu)) && (d_s1.ra_value <  trap_b)) ||
		((|(to_mask & ToGtu)) && (d_s1.ra_value >  trap_b));

	// CRM mask and mcrxr field insert, field 0 is the top nibble
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			crf_mask[4*i +: 4] = {4{d_s1.field_value[i]}};
			cr_xer[4*i +: 4]   = (3'(7 - i) == d_s1.field_value[2:0]) ? xer_q
			                                                          : cr_q[4*i +: 4];
		end
	end

	assign fault = (type_s1 >= REQ_MFMSR) && (type_s1 <= REQ_RFI) && (|(msr_q & MsrPrBit));

	always_comb begin
		cr_nx  = cr_q;
		msr_nx = msr_q;
		xer_nx = xer_q;
		npc_nx = d_s1.cur_pc + 32'd4;
		rd_nx  = '0;
		rdw_nx = 1'b0;
		ifl_nx = 1'b0;
		dfl_nx = 1'b0;
		exc_nx = EXC_NONE;
		if (fault) begin
			npc_nx = d_s1.cur_pc;
			exc_nx = EXC_PRIV;
		end else begin
			case (type_s1)
				REQ_TW, REQ_TWI: begin
					if (trap_hit) exc_nx = EXC_TRAP;
				end
				REQ_MTCRF: cr_nx = (cr_q & ~crf_mask) | (d_s1.rs_value & crf_mask);
				REQ_MCRXR: begin
					cr_nx  = cr_xer;
					xer_nx = '0;
				end
				REQ_MFCR: begin
					rd_nx  = cr_q;
					rdw_nx = 1'b1;
				end
				REQ_MFMSR: begin
					rd_nx  = msr_q;
					rdw_nx = 1'b1;
				end
				REQ_MTMSR: begin
					msr_nx = d_s1.rs_value;
					ifl_nx = |((msr_q ^ d_s1.rs_value) & MsrIrBit);
					dfl_nx = |((msr_q ^ d_s1.rs_value) & MsrDrBit);
				end
				REQ_MFSR, REQ_MFSRIN: begin
					rd_nx  = seg_val;
					rdw_nx = 1'b1;
				end
				REQ_RFI: begin
					msr_nx = (msr_q & ~(RfiKeepMask | RfiClearExtra))
					         | (d_s1.srr1_value & RfiKeepMask);
					npc_nx = {d_s1.srr0_value[31:2], 2'b00};
				end
				REQ_SC:   exc_nx = EXC_SYSCALL;
				REQ_XERW: xer_nx = d_s1.rs_value[31:28];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q      <= '0;
			msr_q     <= '0;
			xer_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_go) begin
				cr_q  <= cr_nx;
				msr_q <= msr_nx;
				xer_q <= xer_nx;
			end
			if (s1_go) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			npc_q <= npc_nx;
			rd_q  <= rd_nx;
			rdw_q <= rdw_nx;
			ifl_q <= ifl_nx;
			dfl_q <= dfl_nx;
			exc_q <= exc_nx;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OutPadW - OutDataW)'(0), dfl_q, ifl_q, rdw_q, rd_q, npc_q};
	assign m_axis_tuser  = exc_q;

	a_priv_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && exc_q == EXC_PRIV) |-> (!rdw_q && !ifl_q && !dfl_q && rd_q == '0))
		else $error("privileged fault word carries side results");

	a_rdw_no_exc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && rdw_q) |-> (exc_q == EXC_NONE))
		else $error("register read word flagged with exception");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && !s1_go) |=> (s1_vld_q && $stable(d_s1) && $stable(type_s1)))
		else $error("execute stage lost its word while stalled");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_go |=> ($stable(cr_q) && $stable(msr_q) && $stable(xer_q)))
		else $error("architected state changed without an executed word");

endmodule
